@@ hdl/ipr_pkg.sv @@
// ----------------------------------------------------------------------------
// Integer pixel replicator package
// Shared field widths, register codes, payload types and the command that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package ipr_pkg;

  // Field widths fixed by the register map and the payload format.
  localparam int unsigned SCALE_W    = 4;
  localparam int unsigned WIDTH_W    = 11;
  localparam int unsigned HEIGHT_W   = 11;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned MAX_HEIGHT = 1024;

  // Compare width that holds any clamped row width (up to 2047).
  localparam int unsigned CMP_W = 13;

  // Command queue between the front end and the back end (power of two).
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SCALE  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  // Input item kinds.
  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_TICK  = 1'b1
  } kind_e;

  typedef struct packed {
    logic               kind;
    logic [COLOR_W-1:0] color;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] out_color;
    logic               last_of_run;
    logic               row_end;
    logic               image_end;
    logic               rejected;
  } out_item_t;

  // Clamped configuration as seen by the front end.
  typedef struct packed {
    logic [SCALE_W-1:0]  scale;
    logic [CMP_W-1:0]    width;
    logic [HEIGHT_W-1:0] height;
  } cfg_t;

  // One run of identical output pixels.
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [SCALE_W-1:0] count;
    logic               rend;
    logic               iend;
    logic               rej;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

@@ hdl/ipr_stream_if.sv @@
// ----------------------------------------------------------------------------
// Integer pixel replicator stream interface
// Valid/ready channel with a typed payload; a transaction completes when
// valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface ipr_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

@@ hdl/ipr_ram.sv @@
// ----------------------------------------------------------------------------
// Integer pixel replicator single-port RAM
// Generic single-port memory with one access per cycle and registered read.
// ----------------------------------------------------------------------------
module ipr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write or read one word per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ipr_front.sv @@
// ----------------------------------------------------------------------------
// Integer pixel replicator front end
// Accepts input transactions, tracks column, row and replay state, keeps the
// line store and turns each pixel and replay tick into a run command for the queue.
// ----------------------------------------------------------------------------
module ipr_front #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_SCALE = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ipr_pkg::cfg_t                   cfg_i,
  ipr_stream_if.sink                      in_i,
  input  logic [ipr_pkg::FIFO_CNT_W-1:0]  fifo_count_i,
  output ipr_pkg::push_t                  push_o
);
  import ipr_pkg::*;

  localparam int unsigned COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RC_W   = (MAX_SCALE > 2) ? $clog2(MAX_SCALE) : 1;
  localparam int unsigned RCMP_W = SCALE_W + 1;

  logic [COL_W-1:0]   column_q, column_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [RC_W-1:0]    rc_q, rc_d;
  logic               replaying_q, replaying_d;
  logic               s1_valid_q, s1_valid_d;
  logic               s1_from_ram_q, s1_from_ram_d;
  cmd_t               s1_cmd_q, s1_cmd_d;

  logic               accept;
  logic               row_last;
  logic               img_last;
  logic               replay_done;
  logic [ROW_W-1:0]   row_next;
  logic               ram_we;
  logic               ram_re;
  logic [COLOR_W-1:0] ram_rdata;

  // Accept only when the queue has room for this item and the one in flight.
  assign in_i.ready = ((fifo_count_i + {{(FIFO_CNT_W-1){1'b0}}, s1_valid_q})
                       < FIFO_CNT_W'(FIFO_DEPTH));
  assign accept     = in_i.valid && in_i.ready;

  // Row, image and replay boundaries.
  assign row_last    = ((CMP_W'(column_q) + CMP_W'(1)) >= cfg_i.width);
  assign img_last    = ((HEIGHT_W'(row_q) + HEIGHT_W'(1)) >= cfg_i.height);
  assign row_next    = img_last ? '0 : (row_q + ROW_W'(1));
  assign replay_done = ((RCMP_W'(rc_q) + RCMP_W'(2)) >= RCMP_W'(cfg_i.scale));

  // Line store: written by source pixels, read by replay ticks.
  ipr_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (column_q),
    .wdata_i (in_i.data.color),
    .rdata_o (ram_rdata)
  );

  // Classify the accepted transaction and advance the row state.
  always_comb begin
    column_d      = column_q;
    row_d         = row_q;
    rc_d          = rc_q;
    replaying_d   = replaying_q;
    s1_valid_d    = 1'b0;
    s1_from_ram_d = 1'b0;
    s1_cmd_d      = '0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    if (accept) begin
      if (in_i.data.kind == KIND_PIXEL) begin
        s1_valid_d = 1'b1;
        if (replaying_q) begin
          // A pixel during replay is dropped and flagged.
          s1_cmd_d.count = SCALE_W'(1);
          s1_cmd_d.rej   = 1'b1;
        end else begin
          ram_we         = 1'b1;
          s1_cmd_d.color = in_i.data.color;
          s1_cmd_d.count = cfg_i.scale;
          if (row_last) begin
            column_d = '0;
            if (cfg_i.scale > SCALE_W'(1)) begin
              replaying_d = 1'b1;
              rc_d        = '0;
            end else begin
              s1_cmd_d.rend = 1'b1;
              s1_cmd_d.iend = img_last;
              row_d         = row_next;
            end
          end else begin
            column_d = column_q + COL_W'(1);
          end
        end
      end else if (replaying_q) begin
        // A tick replays one stored pixel.
        ram_re         = 1'b1;
        s1_valid_d     = 1'b1;
        s1_from_ram_d  = 1'b1;
        s1_cmd_d.count = cfg_i.scale;
        s1_cmd_d.rend  = row_last;
        if (row_last) begin
          column_d = '0;
          if (replay_done) begin
            replaying_d   = 1'b0;
            rc_d          = '0;
            s1_cmd_d.iend = img_last;
            row_d         = row_next;
          end else begin
            rc_d = rc_q + RC_W'(1);
          end
        end else begin
          column_d = column_q + COL_W'(1);
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q      <= '0;
      row_q         <= '0;
      rc_q          <= '0;
      replaying_q   <= 1'b0;
      s1_valid_q    <= 1'b0;
      s1_from_ram_q <= 1'b0;
    end else begin
      column_q      <= column_d;
      row_q         <= row_d;
      rc_q          <= rc_d;
      replaying_q   <= replaying_d;
      s1_valid_q    <= s1_valid_d;
      s1_from_ram_q <= s1_from_ram_d;
    end
  end

  // Command payload waiting for the line store read.
  always_ff @(posedge clk_i) begin
    s1_cmd_q <= s1_cmd_d;
  end

  // Merge the read data into the command and hand it to the queue.
  always_comb begin
    push_o.valid = s1_valid_q;
    push_o.cmd   = s1_cmd_q;
    if (s1_from_ram_q) begin
      push_o.cmd.color = ram_rdata;
    end
  end

endmodule

@@ hdl/ipr_fifo.sv @@
// ----------------------------------------------------------------------------
// Integer pixel replicator command queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ipr_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ipr_pkg::push_t                  push_i,
  input  logic                            pop_i,
  output ipr_pkg::head_t                  head_o,
  output logic [ipr_pkg::FIFO_CNT_W-1:0]  count_o
);
  import ipr_pkg::*;

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;

  // Pointers wrap naturally since the depth is a power of two.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.valid) begin
      wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + FIFO_PTR_W'(1);
    end
    if (push_i.valid && !pop_i) begin
      count_d = count_q + FIFO_CNT_W'(1);
    end else if (!push_i.valid && pop_i) begin
      count_d = count_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign count_o      = count_q;

`ifndef ASSERT_OFF
  // The front end credit must keep the queue from overflowing.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> (count_q < FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("command queue written while full");

  // The back end only pops entries that exist.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("command queue read while empty");
`endif

endmodule

@@ hdl/ipr_back.sv @@
// ----------------------------------------------------------------------------
// Integer pixel replicator back end
// Expands each queued run command into its copies, one output transaction
// per cycle while out_o accepts them, through a registered output stage.
// ----------------------------------------------------------------------------
module ipr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ipr_pkg::head_t  head_i,
  output logic            pop_o,
  ipr_stream_if.source    out_o
);
  import ipr_pkg::*;

  logic [SCALE_W-1:0] k_q, k_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_data_q, out_data_d;
  logic               load;
  logic               last;

  // The output register takes a new copy when empty or being drained.
  assign load = !out_valid_q || out_o.ready;
  assign last = ((k_q + SCALE_W'(1)) == head_i.cmd.count);

  always_comb begin
    k_d         = k_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = head_i.valid;
      if (head_i.valid) begin
        out_data_d.out_color   = head_i.cmd.color;
        out_data_d.last_of_run = last;
        out_data_d.row_end     = last && head_i.cmd.rend;
        out_data_d.image_end   = last && head_i.cmd.iend;
        out_data_d.rejected    = head_i.cmd.rej;
        if (last) begin
          pop_o = 1'b1;
          k_d   = '0;
        end else begin
          k_d = k_q + SCALE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

`ifndef ASSERT_OFF
  // A run in progress keeps its command at the head of the queue.
  a_run_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_q != '0) |-> head_i.valid)
    else $error("run copy counter active without a queued command");

  // A rejected pixel is a single copy with no row or image marks.
  a_reject_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.rejected) |->
      (out_o.data.last_of_run && !out_o.data.row_end && !out_o.data.image_end))
    else $error("rejected result carries wrong marks");

  // The image end is always the end of a row and of a run.
  a_image_end_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.image_end) |->
      (out_o.data.row_end && out_o.data.last_of_run))
    else $error("image end without row end");
`endif

endmodule

@@ hdl/integer_pixel_replicator.sv @@
// ----------------------------------------------------------------------------
// Integer pixel replicator
// Nearest-neighbor integer upscaler for ARGB8888 pixels.
//
// Usage: source pixels (kind 0) enter on in_i one row at a time; each is
// stored in the line store and leaves on out_o as scale copies. After the
// last pixel of a row the block replays the stored row scale-1 times, one
// stored pixel per tick transaction (kind 1). A pixel sent during replay
// yields one rejected result and is dropped; a tick outside replay yields
// nothing. Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i
// while the block is idle.
// Path: an accepted item passes the stage-1 register, the command queue and
// the output register before its first copy is valid. Throughput: out_o
// carries one copy per cycle while out_o.ready is high; in_i takes one
// transaction per cycle as long as the four-entry command queue has room.
// Reset: configuration registers return to 1, column, row and replay state
// clear; line store contents are undefined until written.
// Stall: when out_o is held off, its register keeps the current copy, the
// queue fills and in_i.ready drops until room frees up.
// ----------------------------------------------------------------------------
module integer_pixel_replicator #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_SCALE = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ipr_stream_if.sink                   in_i,
  ipr_stream_if.source                 out_o,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [ipr_pkg::WIDTH_W-1:0]  cfg_data_i
);
  import ipr_pkg::*;

  logic [SCALE_W-1:0]    scale_q;
  logic [WIDTH_W-1:0]    width_q;
  logic [HEIGHT_W-1:0]   height_q;
  cfg_t                  cfg;
  push_t                 push;
  head_t                 head;
  logic                  pop;
  logic [FIFO_CNT_W-1:0] fifo_count;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= SCALE_W'(1);
      width_q  <= WIDTH_W'(1);
      height_q <= HEIGHT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCALE:  scale_q  <= cfg_data_i[SCALE_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp each register into its legal range: zero acts as one.
  always_comb begin
    if (scale_q == '0) begin
      cfg.scale = SCALE_W'(1);
    end else if ((SCALE_W + 1)'(scale_q) > (SCALE_W + 1)'(MAX_SCALE)) begin
      cfg.scale = SCALE_W'(MAX_SCALE);
    end else begin
      cfg.scale = scale_q;
    end
    if (width_q == '0) begin
      cfg.width = CMP_W'(1);
    end else if (CMP_W'(width_q) > CMP_W'(MAX_WIDTH)) begin
      cfg.width = CMP_W'(MAX_WIDTH);
    end else begin
      cfg.width = CMP_W'(width_q);
    end
    if (height_q == '0) begin
      cfg.height = HEIGHT_W'(1);
    end else if (height_q > HEIGHT_W'(MAX_HEIGHT)) begin
      cfg.height = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      cfg.height = height_q;
    end
  end

  ipr_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_i         (in_i),
    .fifo_count_i (fifo_count),
    .push_o       (push)
  );

  ipr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (fifo_count)
  );

  ipr_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

@@ dv/integer_pixel_replicator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer pixel replicator testbench
// Drives source pixels and replay ticks through the valid/ready input
// channel, predicts every scaled output pixel with a behavioral upscaler
// kept in step with the accepted transactions, and compares each output
// transaction field by field. A directed opening covers the register
// extremes, rejection, ignored ticks and configuration changes mid-row and
// mid-replay. Random rows then follow under several idling patterns, with
// a long output hold-off and a full drain between phases.
// ----------------------------------------------------------------------------
module integer_pixel_replicator_tb;
  import ipr_pkg::*;

  localparam int unsigned MAX_WIDTH_C = 1024;
  localparam int unsigned MAX_SCALE_C = 8;
  localparam int          HALF_PERIOD = 6;
  localparam int          RESET_CYCLES = 12;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          STALL_LIMIT = 2000;
  localparam int          HOLD_OFF_CYCLES = 80;
  localparam int          RANDOM_PHASES = 4;
  localparam int          PHASE_ITEMS = 22;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [1:0]           cfg_idx_i;
  logic [WIDTH_W-1:0]   cfg_data_i;

  ipr_stream_if #(.payload_t(in_item_t))  in_if ();
  ipr_stream_if #(.payload_t(out_item_t)) out_if ();

  integer_pixel_replicator #(
    .MAX_WIDTH(MAX_WIDTH_C),
    .MAX_SCALE(MAX_SCALE_C)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock generation.
  always begin
    clk_i = 1'b1;
    #HALF_PERIOD;
    clk_i = 1'b0;
    #HALF_PERIOD;
  end

  // Source items waiting to be sent and scaled pixels still expected.
  in_item_t  src_items_q[$];
  out_item_t scaled_pixels_q[$];

  int unsigned send_gap_pct;
  int unsigned rx_stall_pct;
  int          rx_hold_cycles;
  int          mismatches;
  int          quiet_cycles;

  // Upscaler state as the block should hold it.
  logic [COLOR_W-1:0]  row_mem [MAX_WIDTH_C];
  logic [ROW_W-1:0]    col_q;
  logic [ROW_W-1:0]    src_row_q;
  logic [2:0]          replay_cnt_q;
  logic                replaying_q;
  logic [SCALE_W-1:0]  scale_reg;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;

  function automatic int clamp_cfg(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Steps to the next source row; returns 1 when the image is complete.
  function automatic bit advance_source_row(input int h);
    if (int'(src_row_q) + 1 >= h) begin
      src_row_q = '0;
      return 1'b1;
    end
    src_row_q = src_row_q + 1'b1;
    return 1'b0;
  endfunction

  // Computes the scaled pixels caused by one accepted input transaction.
  task automatic predict_upscale(input in_item_t item);
    int                 s;
    int                 w;
    int                 h;
    int                 n;
    bit                 row_last;
    bit                 rend;
    bit                 iend;
    bit                 rej;
    logic [COLOR_W-1:0] color;
    out_item_t          res;
    s = clamp_cfg(int'(scale_reg), MAX_SCALE_C);
    w = clamp_cfg(int'(width_reg), MAX_WIDTH_C);
    h = clamp_cfg(int'(height_reg), MAX_HEIGHT);
    row_last = (int'(col_q) + 1 >= w);
    rend = 1'b0;
    iend = 1'b0;
    rej = 1'b0;
    n = s;
    color = item.color;
    if (item.kind == KIND_PIXEL) begin
      if (replaying_q) begin
        // A pixel during replay is dropped with a single rejected result.
        rej = 1'b1;
        n = 1;
        color = '0;
      end else begin
        row_mem[col_q] = item.color;
        if (row_last) begin
          col_q = '0;
          if (s > 1) begin
            replaying_q = 1'b1;
            replay_cnt_q = '0;
          end else begin
            rend = 1'b1;
            iend = advance_source_row(h);
          end
        end else begin
          col_q = col_q + 1'b1;
        end
      end
    end else if (!replaying_q) begin
      // Ticks outside replay have no effect.
      n = 0;
    end else begin
      color = row_mem[col_q];
      if (row_last) begin
        rend = 1'b1;
        col_q = '0;
        if (int'(replay_cnt_q) + 2 >= s) begin
          replaying_q = 1'b0;
          replay_cnt_q = '0;
          iend = advance_source_row(h);
        end else begin
          replay_cnt_q = replay_cnt_q + 1'b1;
        end
      end else begin
        col_q = col_q + 1'b1;
      end
    end
    for (int k = 0; k < n; k++) begin
      res.out_color   = color;
      res.last_of_run = (k == n - 1);
      res.row_end     = (k == n - 1) && rend;
      res.image_end   = (k == n - 1) && iend;
      res.rejected    = rej;
      scaled_pixels_q.push_back(res);
    end
  endtask

  task automatic check_field(input string field, input logic [COLOR_W-1:0] want,
                             input logic [COLOR_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 100) begin
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    end
  endtask

  // Input driver: predicts each accepted transaction and offers the next item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        predict_upscale(in_if.data);
      end
      if (!in_if.valid || in_if.ready) begin
        if (src_items_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_if.valid <= 1'b1;
          in_if.data  <= src_items_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each transaction and throttles ready.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (scaled_pixels_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 100) begin
            $display("%0t ns: unexpected pixel, expected none, actual %h", $time,
                     out_if.data);
          end
        end else begin
          want = scaled_pixels_q.pop_front();
          check_field("out_color", want.out_color, out_if.data.out_color);
          check_field("last_of_run", want.last_of_run, out_if.data.last_of_run);
          check_field("row_end", want.row_end, out_if.data.row_end);
          check_field("image_end", want.image_end, out_if.data.image_end);
          check_field("rejected", want.rejected, out_if.data.rejected);
        end
      end
      // A requested hold-off keeps ready low for its whole length.
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles <= rx_hold_cycles - 1;
        out_if.ready   <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any transaction or register write.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Writes all three registers, one per clock edge.
  task automatic set_config(input logic [WIDTH_W-1:0] scale_raw,
                            input logic [WIDTH_W-1:0] width_raw,
                            input logic [WIDTH_W-1:0] height_raw);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SCALE;
    cfg_data_i <= scale_raw;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_WIDTH;
    cfg_data_i <= width_raw;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HEIGHT;
    cfg_data_i <= height_raw;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    scale_reg  = scale_raw[SCALE_W-1:0];
    width_reg  = width_raw;
    height_reg = height_raw;
    @(negedge clk_i);
  endtask

  // Holds the sender back until every expected pixel has arrived.
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (src_items_q.size() != 0 || in_if.valid || scaled_pixels_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic queue_item(input kind_e kind, input logic [COLOR_W-1:0] color);
    in_item_t item;
    item.kind  = kind;
    item.color = color;
    src_items_q.push_back(item);
  endtask

  // Queues whole rows: source pixels, then the replay ticks, with some
  // ignored ticks and rejected pixels mixed in.
  task automatic queue_rows(input int min_items);
    int s;
    int w;
    int sent;
    s = clamp_cfg(int'(scale_reg), MAX_SCALE_C);
    w = clamp_cfg(int'(width_reg), MAX_WIDTH_C);
    sent = 0;
    while (sent < min_items) begin
      for (int c = 0; c < w; c++) begin
        if ($urandom_range(9) == 0) queue_item(KIND_TICK, $urandom);
        queue_item(KIND_PIXEL, $urandom);
      end
      for (int t = 0; t < (s - 1) * w; t++) begin
        if ($urandom_range(9) == 0) queue_item(KIND_PIXEL, $urandom);
        queue_item(KIND_TICK, $urandom);
      end
      sent += s * w;
    end
  endtask

  // Stimulus sequence.
  initial begin : stimulus
    logic [WIDTH_W-1:0] scale_raw;
    logic [WIDTH_W-1:0] width_raw;
    logic [WIDTH_W-1:0] height_raw;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_SCALE;
    cfg_data_i     = '0;
    in_if.valid    = 1'b0;
    in_if.data     = '0;
    out_if.ready   = 1'b0;
    send_gap_pct   = 0;
    rx_stall_pct   = 0;
    rx_hold_cycles = 0;
    mismatches     = 0;
    quiet_cycles   = 0;
    col_q          = '0;
    src_row_q      = '0;
    replay_cnt_q   = '0;
    replaying_q    = 1'b0;
    scale_reg      = 4'd1;
    width_reg      = 11'd1;
    height_reg     = 11'd1;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values: unity scale, one-pixel rows, one-row images.
    queue_item(KIND_PIXEL, 32'h0000_0000);
    queue_item(KIND_PIXEL, 32'hFFFF_FFFF);
    queue_item(KIND_TICK, 32'hFFFF_FFFF);
    wait_drained();

    // Scale above range saturates to eight; rejected pixel and ignored tick.
    set_config(11'h7FF, 11'd1, 11'd2);
    queue_item(KIND_PIXEL, 32'hA5A5_5A5A);
    queue_item(KIND_PIXEL, 32'h1234_5678);
    repeat (7) queue_item(KIND_TICK, 32'h0);
    queue_item(KIND_TICK, 32'h0);
    queue_item(KIND_PIXEL, 32'h5A5A_A5A5);
    repeat (7) queue_item(KIND_TICK, 32'hFFFF_FFFF);
    wait_drained();

    // Zero in every register acts as one.
    set_config(11'd0, 11'd0, 11'd0);
    queue_item(KIND_PIXEL, 32'hDEAD_BEEF);
    wait_drained();

    // Width beyond range, then narrowed mid-row so the next pixel ends it.
    set_config(11'd2, 11'h7FF, 11'h7FF);
    repeat (3) queue_item(KIND_PIXEL, $urandom);
    wait_drained();
    set_config(11'd2, 11'd2, 11'h7FF);
    queue_item(KIND_PIXEL, $urandom);
    repeat (2) queue_item(KIND_TICK, $urandom);
    wait_drained();

    // Scale lowered mid-replay to the replay count: replay ends after this row.
    set_config(11'd4, 11'd2, 11'd1);
    repeat (2) queue_item(KIND_PIXEL, $urandom);
    repeat (2) queue_item(KIND_TICK, $urandom);
    wait_drained();
    set_config(11'd1, 11'd2, 11'd1);
    repeat (2) queue_item(KIND_TICK, $urandom);
    wait_drained();

    // Random rows under each idling pattern.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if ($urandom_range(4) == 0) begin
        width_raw = 11'($urandom_range(7, 20));
        scale_raw = 11'($urandom_range(1, 3));
      end else begin
        width_raw = 11'($urandom_range(0, 6));
        if ($urandom_range(4) == 0) scale_raw = 11'($urandom_range(0, 15));
        else scale_raw = 11'($urandom_range(1, 8));
      end
      // Bits above the scale field carry no meaning.
      if ($urandom_range(3) == 0) scale_raw[WIDTH_W-1:SCALE_W] = 7'($urandom);
      height_raw = 11'($urandom_range(0, 4));
      set_config(scale_raw, width_raw, height_raw);
      case (ph % 4)
        0: begin
          send_gap_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          send_gap_pct = 56;
          rx_stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          rx_stall_pct = 56;
        end
        default: begin
          send_gap_pct = 30;
          rx_stall_pct = 30;
        end
      endcase
      // Long output hold-off while the sender keeps offering items.
      if (ph == 0) rx_hold_cycles = HOLD_OFF_CYCLES;
      queue_rows(PHASE_ITEMS);
      wait_drained();
    end

    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && scaled_pixels_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
